// File: sv/sha512_pkg.sv
package sha512_pkg;

	// Eight 64-bit words of chaining or working state, word 0 first.
	typedef logic [0:7][63:0] sha512_hash_t;

	// Top-level sequencer states.
	typedef enum logic [1:0] {
		T_IDLE,
		T_COMP,
		T_PAD,
		T_OUT
	} sha512_top_state_t;

	// Round engine states.
	typedef enum logic [1:0] {
		C_IDLE,
		C_ROUND,
		C_FOLD
	} sha512_core_state_t;

	// Commands from the sequencer to the round engine.
	typedef struct packed {
		logic        push;
		logic [63:0] word;
		logic        start;
		logic        restart;
	} sha512_cmd_t;

	localparam int unsigned NUM_ROUNDS   = 80;
	localparam int unsigned BLOCK_WORDS  = 16;
	localparam int unsigned DIGEST_WORDS = 8;

	localparam logic [63:0] PAD_MARKER = 64'h8000_0000_0000_0000;

	localparam sha512_hash_t INIT_H = {
		64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
		64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
		64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
		64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
	};

	localparam logic [0:NUM_ROUNDS-1][63:0] ROUND_K = {
		64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
		64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
		64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
		64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
		64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
		64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
		64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
		64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
		64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
		64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
		64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
		64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
		64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
		64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
		64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
		64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
		64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
		64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
		64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
		64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
	};

endpackage

// File: sv/sha512_stream_if.sv
// Message channel: one word of the message per transfer.
interface sha512_msg_if;
	logic        valid;
	logic        ready;
	logic [63:0] msg_word;
	logic [3:0]  byte_count;
	logic        last_word;

	modport source (output valid, output msg_word, output byte_count, output last_word,
		input ready);
	modport sink (input valid, input msg_word, input byte_count, input last_word,
		output ready);
endinterface

// Digest channel: one word of the final hash per transfer.
interface sha512_dig_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic [2:0]  word_index;
	logic        digest_end;

	modport source (output valid, output digest_word, output word_index, output digest_end,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input digest_end,
		output ready);
endinterface

// File: sv/sha512_core.sv
module sha512_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sha512_pkg::sha512_cmd_t  cmd,
	output logic                     done,
	output sha512_pkg::sha512_hash_t hash
);
	import sha512_pkg::*;

	localparam int unsigned RW = $clog2(NUM_ROUNDS);

	function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

	sha512_core_state_t state_q, state_d;
	logic [RW-1:0]      round_q;
	logic [63:0]        w_q [BLOCK_WORDS];
	sha512_hash_t       v_q;
	sha512_hash_t       h_q;

	logic [63:0] w_next, t1, t2, ch, maj, big0, big1, s0, s1;

	// Message schedule: the shift line holds w[t] .. w[t+15].
	always_comb begin
		s1     = rotr(w_q[14], 19) ^ rotr(w_q[14], 61) ^ (w_q[14] >> 6);
		s0     = rotr(w_q[1], 1) ^ rotr(w_q[1], 8) ^ (w_q[1] >> 7);
		w_next = s1 + w_q[9] + s0 + w_q[0];
	end

	// One compression round on the working variables.
	always_comb begin
		ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		big1 = rotr(v_q[4], 14) ^ rotr(v_q[4], 18) ^ rotr(v_q[4], 41);
		big0 = rotr(v_q[0], 28) ^ rotr(v_q[0], 34) ^ rotr(v_q[0], 39);
		t1   = v_q[7] + big1 + ch + ROUND_K[round_q] + w_q[0];
		t2   = big0 + maj;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			C_IDLE: begin
				if (cmd.start) begin
					state_d = C_ROUND;
				end
			end
			C_ROUND: begin
				if (round_q == RW'(NUM_ROUNDS - 1)) begin
					state_d = C_FOLD;
				end
			end
			C_FOLD: begin
				state_d = C_IDLE;
			end
			default: begin
				state_d = C_IDLE;
			end
		endcase
	end

	always_comb begin
		done = (state_q == C_FOLD);
		hash = h_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			round_q <= '0;
			h_q     <= INIT_H;
		end else begin
			state_q <= state_d;
			if (state_q == C_ROUND) begin
				round_q <= round_q + RW'(1);
			end else begin
				round_q <= '0;
			end
			if (state_q == C_FOLD) begin
				for (int i = 0; i < DIGEST_WORDS; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
			end else if (cmd.restart) begin
				h_q <= INIT_H;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_ROUND) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[BLOCK_WORDS - 1] <= w_next;
			v_q <= {t1 + t2, v_q[0], v_q[1], v_q[2], v_q[3] + t1, v_q[4], v_q[5], v_q[6]};
		end else begin
			if (cmd.push) begin
				for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
					w_q[i] <= w_q[i + 1];
				end
				w_q[BLOCK_WORDS - 1] <= cmd.word;
			end
			if (cmd.start) begin
				v_q <= h_q;
			end
		end
	end

endmodule

// File: sv/sha512_stream_hasher.sv
// Channel   Modport  Transfer                         Payload
// message   sink     one message word per handshake   msg_word, byte_count, last_word
// digest    source   one digest word per handshake    digest_word, word_index, digest_end
//
// A message word is taken while a block fills. The sixteenth word of a
// block starts the shared round unit, which runs 80 rounds at one per cycle, then a
// fold step that adds the working variables into the hash state.
// After the last word the padding words enter one per cycle, followed by one or two
// compressions, then the eight digest words. Reset loads the initial hash values
// directly; no clearing pass is needed. The digest word is held until it is taken,
// and no message word is taken while the unit works or the digest is shown.
module sha512_stream_hasher (
	input  logic         clk,
	input  logic         arst_n,
	sha512_msg_if.sink   message,
	sha512_dig_if.source digest
);
	import sha512_pkg::*;

	localparam int unsigned FW = $clog2(BLOCK_WORDS);
	localparam int unsigned IW = $clog2(DIGEST_WORDS);

	sha512_top_state_t state_q, state_d;
	logic [FW-1:0]     fill_q;
	logic [IW-1:0]     idx_q;
	logic [127:0]      len_q;
	// Padding flags: the message has ended, the marker word is still owed,
	// the high length word has gone in, and the low length word has gone in.
	logic              padding_q;
	logic              marker_q;
	logic              len_hi_q;
	logic              final_q;

	sha512_cmd_t  cmd;
	logic         core_done;
	sha512_hash_t hash;

	logic        in_acc, out_acc, full_word;
	logic [6:0]  add_bits;
	logic [6:0]  keep_shift;
	logic [6:0]  mark_shift;
	logic [63:0] tail_word;

	assign in_acc  = message.valid && message.ready;
	assign out_acc = digest.valid && digest.ready;

	// A last word counts as full when its byte count is eight or more.
	always_comb begin
		full_word  = !message.last_word || message.byte_count[3];
		add_bits   = full_word ? 7'd64 : {1'b0, message.byte_count[2:0], 3'b000};
		keep_shift = 7'd64 - {1'b0, message.byte_count[2:0], 3'b000};
		mark_shift = 7'd56 - {1'b0, message.byte_count[2:0], 3'b000};
		// A zero byte count clears the whole word, leaving only the marker.
		tail_word  = (message.msg_word & ({64{1'b1}} << keep_shift)) |
			(64'h80 << mark_shift);
	end

	always_comb begin
		cmd.push    = 1'b0;
		cmd.word    = '0;
		cmd.restart = out_acc && (idx_q == IW'(DIGEST_WORDS - 1));
		case (state_q)
			T_IDLE: begin
				cmd.push = in_acc;
				cmd.word = full_word ? message.msg_word : tail_word;
			end
			T_PAD: begin
				cmd.push = 1'b1;
				if (marker_q) begin
					cmd.word = PAD_MARKER;
				end else if (len_hi_q) begin
					cmd.word = len_q[63:0];
				end else if (fill_q == FW'(BLOCK_WORDS - 2)) begin
					cmd.word = len_q[127:64];
				end else begin
					cmd.word = '0;
				end
			end
			default: begin
				cmd.push = 1'b0;
			end
		endcase
		cmd.start = cmd.push && (fill_q == FW'(BLOCK_WORDS - 1));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			T_IDLE: begin
				if (in_acc) begin
					if (cmd.start) begin
						state_d = T_COMP;
					end else if (message.last_word) begin
						state_d = T_PAD;
					end
				end
			end
			T_PAD: begin
				if (cmd.start) begin
					state_d = T_COMP;
				end
			end
			T_COMP: begin
				if (core_done) begin
					if (final_q) begin
						state_d = T_OUT;
					end else if (padding_q) begin
						state_d = T_PAD;
					end else begin
						state_d = T_IDLE;
					end
				end
			end
			T_OUT: begin
				if (cmd.restart) begin
					state_d = T_IDLE;
				end
			end
			default: begin
				state_d = T_IDLE;
			end
		endcase
	end

	always_comb begin
		message.ready      = (state_q == T_IDLE);
		digest.valid       = (state_q == T_OUT);
		digest.digest_word = hash[idx_q];
		digest.word_index  = idx_q;
		digest.digest_end  = (idx_q == IW'(DIGEST_WORDS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			fill_q    <= '0;
			idx_q     <= '0;
			len_q     <= '0;
			padding_q <= 1'b0;
			marker_q  <= 1'b0;
			len_hi_q  <= 1'b0;
			final_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push) begin
				fill_q <= fill_q + FW'(1);
			end
			if (state_q == T_IDLE && in_acc) begin
				len_q <= len_q + {121'b0, add_bits};
				if (message.last_word) begin
					padding_q <= 1'b1;
					marker_q  <= message.byte_count[3];
					len_hi_q  <= 1'b0;
					final_q   <= 1'b0;
				end
			end
			if (state_q == T_PAD) begin
				if (marker_q) begin
					marker_q <= 1'b0;
				end else if (len_hi_q) begin
					final_q <= 1'b1;
				end else if (fill_q == FW'(BLOCK_WORDS - 2)) begin
					len_hi_q <= 1'b1;
				end
			end
			if (out_acc) begin
				idx_q <= idx_q + IW'(1);
				if (cmd.restart) begin
					len_q     <= '0;
					padding_q <= 1'b0;
					final_q   <= 1'b0;
				end
			end
		end
	end

	sha512_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.done   (core_done),
		.hash   (hash)
	);

	// The two channels never run at the same time.
	assert property (@(posedge clk) disable iff (!arst_n)
		message.ready |-> !digest.valid)
		else $error("message taken while digest is shown");

	// The digest always goes out with the block buffer empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid |-> (fill_q == '0))
		else $error("digest shown with words left in the block");

	// After the final digest word the engine is ready for a new message.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && digest.digest_end) |=> (message.ready && len_q == '0))
		else $error("engine not restarted after the digest");

	// The round unit only finishes while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		core_done |-> (state_q == T_COMP))
		else $error("compression ended outside a wait");

endmodule
